[rtl/ffspa_pkg.sv]
// shared types and constants for the first-fit slot pool allocator
package ffspa_pkg;
  localparam int NUM_SLOTS = 8;
  localparam int POOL_BYTES = 4096;
  localparam int SLOT_W = 3;
  localparam int LEN_W = 13;
  localparam int CNT_W = 4;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE = 2'd1;
  localparam logic [1:0] ACT_DEFRAG = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOROOM = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] KIND_ANS = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_PICK, S_STEP, S_FINISH, S_OUT
  } state_t;

  typedef struct packed {
    logic held;
    len_t off;
    len_t len;
    slot_t idx;
  } entry_t;

  // key used to order blocks: held blocks first by (offset, slot)
  function automatic logic entry_lt(entry_t a, entry_t b);
    if (a.held != b.held) return a.held;
    if (a.off != b.off) return a.off < b.off;
    return a.idx < b.idx;
  endfunction
endpackage

[rtl/ffspa_cell.sv]
// one slot cell: holds a block and compares against the walk key
module ffspa_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ffspa_pkg::slot_t      my_idx,
  input  logic                  wr_en,
  input  ffspa_pkg::entry_t     wr_data,
  input  logic                  mark_clr,
  input  logic                  mark_set,
  input  ffspa_pkg::entry_t     pick_in,
  input  ffspa_pkg::entry_t     best_in,
  output ffspa_pkg::entry_t     best_out,
  output ffspa_pkg::entry_t     ent
);
  import ffspa_pkg::*;
  entry_t ent_r;
  logic done_r;
  entry_t me;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
      done_r <= 1'b0;
    end else begin
      if (wr_en) ent_r <= wr_data;
      if (mark_clr) done_r <= 1'b0;
      else if (mark_set && pick_in.held && pick_in.idx == my_idx) done_r <= 1'b1;
    end
  end

  always_comb begin
    me = ent_r;
    me.idx = my_idx;
    if (done_r) me.held = 1'b0;
    best_out = entry_lt(me, best_in) ? me : best_in;
  end

  assign ent = '{held: ent_r.held, off: ent_r.off, len: ent_r.len, idx: my_idx};
endmodule

[rtl/first_fit_slot_pool_allocator.sv]
// top level: slot cell row plus the walk sequencer
// Searching allocate and defrag walk the row of eight slot cells in address order.
// Each walk step picks the lowest unvisited block by a min chain across the
// cells, so a searching allocate passes through the pick state, walk steps
// until a fit is found or the held blocks run out, then the finish and output
// states; a defrag takes the same path but holds in a step while a move beat
// waits on a stalled output. Shrink-in-place, free and unused-code requests go
// from the pick state straight to the output state. One item is worked at a time:
// the input stalls until the last beat of the previous item has been taken.
module first_fit_slot_pool_allocator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [12:0]           cfg_pool_size,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [2:0]            in_slot,
  input  logic [12:0]           in_request_length,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [1:0]            out_kind,
  output logic [12:0]           out_offset,
  output logic [12:0]           out_source,
  output logic [12:0]           out_length,
  output logic [3:0]            out_moved_count,
  output logic                  out_last
);
  import ffspa_pkg::*;

  state_t state_r, state_nxt;
  logic [12:0] pool_r;
  logic [1:0] act_r;
  slot_t slot_r;
  len_t req_r;
  logic [13:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] moved_r;
  entry_t pick_r;
  logic found_r;

  logic ov_r;
  logic [1:0] o_status_r, o_kind_r;
  len_t o_off_r, o_src_r, o_len_r;
  logic [CNT_W-1:0] o_cnt_r;
  logic o_last_r;

  entry_t chain [NUM_SLOTS+1];
  entry_t ents [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] wr_en;
  entry_t wr_data;
  logic mark_clr, mark_set;

  assign chain[0] = '{held: 1'b0, off: '1, len: '0, idx: '1};

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    ffspa_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(slot_t'(g)),
      .wr_en(wr_en[g]), .wr_data(wr_data),
      .mark_clr(mark_clr), .mark_set(mark_set), .pick_in(chain[NUM_SLOTS]),
      .best_in(chain[g]), .best_out(chain[g+1]), .ent(ents[g])
    );
  end

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || ov_r;
  wire accept = in_valid && !in_stall;

  logic [13:0] pool_eff;
  assign pool_eff = (pool_r > 13'(POOL_BYTES)) ? 14'(POOL_BYTES) : {1'b0, pool_r};

  entry_t cur_e;
  assign cur_e = ents[slot_r];
  logic [13:0] blk_end;
  assign blk_end = {1'b0, pick_r.off} + {1'b0, pick_r.len};

  logic shrink, grant;
  assign shrink = cur_e.held && cur_e.len >= req_r;
  assign grant = found_r || (cur_r + 14'(req_r) <= pool_eff);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_PICK;
      S_PICK: begin
        if (act_r == ACT_DEFRAG) state_nxt = S_STEP;
        else if (act_r == ACT_ALLOC && !shrink) state_nxt = S_STEP;
        else state_nxt = S_OUT;
      end
      S_STEP: begin
        if (!pick_r.held || (act_r == ACT_ALLOC && found_r)) state_nxt = S_FINISH;
        else state_nxt = S_STEP;
      end
      S_FINISH: if (out_free) state_nxt = S_OUT;
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic step_ok;
  always_comb begin
    step_ok = 1'b1;
    if (state_r == S_STEP && act_r == ACT_DEFRAG && pick_r.held &&
        {1'b0, pick_r.off} > cur_r && !out_free) step_ok = 1'b0;
  end

  // walk_en: the picked block is taken into the walk this cycle
  logic walk_en, fit, move_en, ov_load;
  assign walk_en = (state_r == S_STEP) && step_ok && pick_r.held &&
                   !(act_r == ACT_ALLOC && found_r);
  assign fit = (act_r == ACT_ALLOC) && ({1'b0, pick_r.off} >= cur_r) &&
               ({1'b0, pick_r.off} - cur_r >= 14'(req_r));
  assign move_en = walk_en && (act_r == ACT_DEFRAG) && ({1'b0, pick_r.off} > cur_r);
  assign ov_load = move_en || (state_r == S_OUT && out_free);

  always_comb begin
    wr_en = '0;
    wr_data = '0;
    mark_clr = (state_r == S_IDLE);
    mark_set = (state_r == S_PICK) || walk_en;
    cur_nxt = cur_r;
    if (walk_en) begin
      if (move_en) begin
        wr_en[pick_r.idx] = 1'b1;
        wr_data = '{held: 1'b1, off: cur_r[12:0], len: pick_r.len, idx: pick_r.idx};
        if (cur_r + 14'(pick_r.len) > cur_r) cur_nxt = cur_r + 14'(pick_r.len);
      end else if (!fit && blk_end > cur_r) cur_nxt = blk_end;
    end
    if (state_r == S_OUT && out_free && act_r == ACT_ALLOC) begin
      if (shrink) begin
        wr_en[slot_r] = 1'b1;
        wr_data = '{held: 1'b1, off: cur_e.off, len: req_r, idx: slot_r};
      end else if (grant) begin
        wr_en[slot_r] = 1'b1;
        wr_data = '{held: 1'b1, off: cur_r[12:0], len: req_r, idx: slot_r};
      end
    end
    if (state_r == S_OUT && out_free && act_r == ACT_FREE) begin
      wr_en[slot_r] = 1'b1;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pool_r <= 13'(POOL_BYTES);
      ov_r <= 1'b0;
      found_r <= 1'b0;
      cur_r <= '0;
      moved_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) pool_r <= cfg_pool_size;
      ov_r <= ov_load || (ov_r && out_stall);
      if (accept) begin
        act_r <= in_action;
        slot_r <= in_slot;
        req_r <= in_request_length;
        cur_r <= '0;
        moved_r <= '0;
        found_r <= 1'b0;
      end else begin
        cur_r <= cur_nxt;
        if (walk_en && fit) found_r <= 1'b1;
        if (move_en) moved_r <= moved_r + 1'b1;
      end
      if (state_r == S_PICK || (state_r == S_STEP && step_ok)) pick_r <= chain[NUM_SLOTS];
      if (move_en) begin
        o_status_r <= ST_OK; o_kind_r <= KIND_MOVE;
        o_off_r <= cur_r[12:0]; o_src_r <= pick_r.off; o_len_r <= pick_r.len;
        o_cnt_r <= '0; o_last_r <= 1'b0;
      end else if (state_r == S_OUT && out_free) begin
        o_src_r <= '0;
        o_last_r <= 1'b1;
        if (act_r == ACT_DEFRAG) begin
          o_status_r <= ST_OK; o_kind_r <= KIND_DONE;
          o_off_r <= '0; o_len_r <= '0; o_cnt_r <= moved_r;
        end else if (act_r == ACT_ALLOC && shrink) begin
          o_status_r <= ST_OK; o_kind_r <= KIND_ANS;
          o_off_r <= cur_e.off; o_len_r <= req_r; o_cnt_r <= '0;
        end else if (act_r == ACT_ALLOC && grant) begin
          o_status_r <= ST_OK; o_kind_r <= KIND_ANS;
          o_off_r <= cur_r[12:0]; o_len_r <= req_r; o_cnt_r <= '0;
        end else if (act_r == ACT_ALLOC) begin
          o_status_r <= ST_NOROOM; o_kind_r <= KIND_ANS;
          o_off_r <= '0; o_len_r <= '0; o_cnt_r <= '0;
        end else begin
          o_status_r <= ST_OK; o_kind_r <= KIND_ANS;
          o_off_r <= '0; o_len_r <= '0; o_cnt_r <= '0;
        end
      end
    end
  end

  assign out_valid = ov_r;
  assign out_status = o_status_r;
  assign out_kind = o_kind_r;
  assign out_offset = o_off_r;
  assign out_source = o_src_r;
  assign out_length = o_len_r;
  assign out_moved_count = o_cnt_r;
  assign out_last = o_last_r;
endmodule

[bench/first_fit_slot_pool_allocator_test.sv]
// testbench for the first-fit slot pool allocator: random and directed requests, predicted answers
`timescale 1ns / 100ps

module first_fit_slot_pool_allocator_test;
  import ffspa_pkg::*;

  localparam int MAX_QUIET = 20000;
  localparam int ACT_UNUSED = 3;

  typedef struct {
    logic [1:0]  action;
    logic [2:0]  slot;
    logic [12:0] req;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [12:0] offset;
    logic [12:0] source;
    logic [12:0] length;
    logic [3:0]  moved_count;
    logic        last;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [12:0] cfg_pool_size = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = '0;
  logic [2:0] in_slot = '0;
  logic [12:0] in_request_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status, out_kind;
  logic [12:0] out_offset, out_source, out_length;
  logic [3:0] out_moved_count;
  logic out_last;

  first_fit_slot_pool_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_pool_size(cfg_pool_size),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_slot(in_slot), .in_request_length(in_request_length),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_kind(out_kind), .out_offset(out_offset), .out_source(out_source),
    .out_length(out_length), .out_moved_count(out_moved_count), .out_last(out_last)
  );

  initial forever #1 clk = ~clk;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int quiet_cycles = 0;
  int hold_off = 0;
  logic long_hold = 1'b0;

  // predictor state
  int unsigned pool_bytes_set = 4096;
  bit          held[NUM_SLOTS];
  int unsigned blk_off[NUM_SLOTS];
  int unsigned blk_len[NUM_SLOTS];

  function automatic answer_t make_answer(logic [1:0] st, logic [1:0] k, int unsigned off,
                                          int unsigned src, int unsigned len,
                                          int unsigned cnt, logic lst);
    answer_t a;
    a.status = st; a.kind = k; a.offset = 13'(off); a.source = 13'(src);
    a.length = 13'(len); a.moved_count = 4'(cnt); a.last = lst;
    return a;
  endfunction

  function automatic int sort_blocks(ref int order[NUM_SLOTS]);
    int n, j;
    n = 0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (held[s]) begin
        j = n;
        while (j > 0 && blk_off[order[j-1]] > blk_off[s]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = s;
        n++;
      end
    end
    return n;
  endfunction

  function automatic void predict_pool(request_t r);
    int order[NUM_SLOTS];
    int n;
    int unsigned cursor, o, e, moved, lim, req;
    bit found;
    req = 32'(r.req);
    if (r.action == ACT_DEFRAG) begin
      n = sort_blocks(order);
      cursor = 0; moved = 0;
      for (int i = 0; i < n; i++) begin
        if (blk_off[order[i]] > cursor) begin
          expected_answers.push_back(make_answer(ST_OK, KIND_MOVE, cursor, blk_off[order[i]],
                                                 blk_len[order[i]], 0, 1'b0));
          blk_off[order[i]] = cursor;
          moved++;
        end
        e = blk_off[order[i]] + blk_len[order[i]];
        if (e > cursor) cursor = e;
      end
      expected_answers.push_back(make_answer(ST_OK, KIND_DONE, 0, 0, 0, moved, 1'b1));
    end else if (r.action == ACT_UNUSED) begin
      expected_answers.push_back(make_answer(ST_OK, KIND_ANS, 0, 0, 0, 0, 1'b1));
    end else if (r.action == ACT_FREE) begin
      held[r.slot] = 0; blk_off[r.slot] = 0; blk_len[r.slot] = 0;
      expected_answers.push_back(make_answer(ST_OK, KIND_ANS, 0, 0, 0, 0, 1'b1));
    end else if (held[r.slot] && blk_len[r.slot] >= req) begin
      blk_len[r.slot] = req;
      expected_answers.push_back(make_answer(ST_OK, KIND_ANS, blk_off[r.slot], 0, req, 0,
                                             1'b1));
    end else begin
      n = sort_blocks(order);
      cursor = 0; found = 0;
      for (int i = 0; i < n && !found; i++) begin
        o = blk_off[order[i]];
        if (o >= cursor && o - cursor >= req) found = 1;
        else begin
          e = o + blk_len[order[i]];
          if (e > cursor) cursor = e;
        end
      end
      lim = pool_bytes_set > POOL_BYTES ? POOL_BYTES : pool_bytes_set;
      if (!found && cursor + req <= lim) found = 1;
      if (!found) begin
        expected_answers.push_back(make_answer(ST_NOROOM, KIND_ANS, 0, 0, 0, 0, 1'b1));
      end else begin
        held[r.slot] = 1; blk_off[r.slot] = cursor; blk_len[r.slot] = req;
        expected_answers.push_back(make_answer(ST_OK, KIND_ANS, cursor, 0, req, 0, 1'b1));
      end
    end
  endfunction

  function automatic request_t make_request(int act, int slot, int req);
    request_t r;
    r.action = 2'(act); r.slot = 3'(slot); r.req = 13'(req);
    return r;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_pool(pending_requests.pop_front());
        send_gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_valid <= 1'b1;
          in_action <= pending_requests[0].action;
          in_slot <= pending_requests[0].slot;
          in_request_length <= pending_requests[0].req;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected beat");
          errors++;
        end else begin
          e = expected_answers.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++;
          end
          if (out_kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, out_kind); errors++;
          end
          if (out_offset !== e.offset) begin
            $error("offset exp %0d got %0d", e.offset, out_offset); errors++;
          end
          if (out_source !== e.source) begin
            $error("source exp %0d got %0d", e.source, out_source); errors++;
          end
          if (out_length !== e.length) begin
            $error("length exp %0d got %0d", e.length, out_length); errors++;
          end
          if (out_moved_count !== e.moved_count) begin
            $error("moved_count exp %0d got %0d", e.moved_count, out_moved_count); errors++;
          end
          if (out_last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_last); errors++;
          end
        end
        hold_off = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) hold_off = 0;
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if (quiet_cycles >= MAX_QUIET) begin
        $display("first_fit_slot_pool_allocator_test NOT OK");
        $finish;
      end
    end
  end

  task automatic drain_and_settle();
    while (pending_requests.size() > 0 || expected_answers.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pool_size(int unsigned v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_pool_size <= 13'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pool_bytes_set = v;
  endtask

  function automatic int draw_length(int unsigned lim);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(0, 8191);
      2: return lim / 8;
      default: return $urandom_range(0, lim / 5 + 1);
    endcase
  endfunction

  task automatic random_phase(int count, int unsigned lim);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      if (r < 11) pending_requests.push_back(make_request(ACT_ALLOC, $urandom_range(0, 7),
                                                          draw_length(lim)));
      else if (r < 16) pending_requests.push_back(make_request(ACT_FREE,
                                                               $urandom_range(0, 7), 0));
      else if (r < 19) pending_requests.push_back(make_request(ACT_DEFRAG,
                                                               $urandom_range(0, 7),
                                                               $urandom_range(0, 8191)));
      else pending_requests.push_back(make_request(ACT_UNUSED, $urandom_range(0, 7),
                                                   $urandom_range(0, 8191)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    pending_requests.push_back(make_request(ACT_ALLOC, 0, 0));
    pending_requests.push_back(make_request(ACT_ALLOC, 1, 100));
    pending_requests.push_back(make_request(ACT_ALLOC, 2, 200));
    pending_requests.push_back(make_request(ACT_ALLOC, 3, 300));
    pending_requests.push_back(make_request(ACT_FREE, 1, 0));
    pending_requests.push_back(make_request(ACT_ALLOC, 4, 50));
    pending_requests.push_back(make_request(ACT_ALLOC, 2, 150));
    pending_requests.push_back(make_request(ACT_ALLOC, 3, 500));
    pending_requests.push_back(make_request(ACT_ALLOC, 5, 8191));
    pending_requests.push_back(make_request(ACT_ALLOC, 6, 4096));
    pending_requests.push_back(make_request(ACT_FREE, 7, 0));
    pending_requests.push_back(make_request(ACT_UNUSED, 7, 8191));
    pending_requests.push_back(make_request(ACT_DEFRAG, 5, 0));
    pending_requests.push_back(make_request(ACT_FREE, 0, 0));
    pending_requests.push_back(make_request(ACT_ALLOC, 7, 2000));
    pending_requests.push_back(make_request(ACT_DEFRAG, 0, 0));
    drain_and_settle();

    // pool shrunk below held blocks, then a full pool
    write_pool_size(64);
    pending_requests.push_back(make_request(ACT_ALLOC, 1, 10));
    pending_requests.push_back(make_request(ACT_ALLOC, 0, 64));
    pending_requests.push_back(make_request(ACT_FREE, 4, 0));
    pending_requests.push_back(make_request(ACT_DEFRAG, 0, 0));
    drain_and_settle();
    write_pool_size(0);
    pending_requests.push_back(make_request(ACT_ALLOC, 6, 0));
    pending_requests.push_back(make_request(ACT_ALLOC, 6, 1));
    drain_and_settle();
    write_pool_size(8191);
    pending_requests.push_back(make_request(ACT_ALLOC, 6, 4096));
    drain_and_settle();

    // receiver held off while the sender keeps offering
    long_hold = 1'b1;
    random_phase(12, 4096);
    repeat (300) @(posedge clk);
    long_hold = 1'b0;
    drain_and_settle();

    write_pool_size(4096);
    random_phase(50, 4096);
    drain_and_settle();
    write_pool_size($urandom_range(100, 1000));
    random_phase(40, pool_bytes_set);
    drain_and_settle();
    write_pool_size(4096);
    random_phase(50, 4096);
    drain_and_settle();

    if (errors == 0) $display("first_fit_slot_pool_allocator_test OK");
    else $display("first_fit_slot_pool_allocator_test NOT OK");
    $finish;
  end
endmodule
